FILE: src/assert_macros.svh
// assertion macros shared by the cursor tracker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define MPCT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define MPCT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `MPCT_ASSERT(lbl, clk, rstn, !(cond), msg)

`else

`define MPCT_ASSERT(lbl, clk, rstn, prop, msg)
`define MPCT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

FILE: src/mpct_pkg.sv
// shared types and constants of the mouse packet cursor tracker
package mpct_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int EDGE_MARGIN = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] BTN_MASK = 3'b111;

    // register reset values
    localparam logic [7:0]  SENS_RESET   = 8'd2;
    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [10:0] HEIGHT_RESET = 11'd768;
    localparam logic [9:0]  BOTTOM_RESET = 10'd767;

    // register indexes
    localparam logic [1:0] CFG_SENSITIVITY = 2'd0;
    localparam logic [1:0] CFG_WIDTH       = 2'd1;
    localparam logic [1:0] CFG_HEIGHT      = 2'd2;
    localparam logic [1:0] CFG_BOTTOM      = 2'd3;

    // one complete packet handed from front to back
    typedef struct packed {
        logic [2:0] buttons;
        logic [7:0] delta_x;
        logic [7:0] delta_y;
    } mpct_entry_t;

    // configuration registers
    typedef struct packed {
        logic [7:0]  sensitivity;
        logic [10:0] screen_width;
        logic [10:0] screen_height;
        logic [9:0]  bottom_row;
    } mpct_cfg_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } mpct_q_stat_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } mpct_div_stat_t;

endpackage

FILE: src/mpct_front.sv
// front end: takes raw mouse bytes and assembles three-byte packets
module mpct_front
    import mpct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,      // data_byte
    input  mpct_q_stat_t q_stat,
    output logic         q_push,
    output mpct_entry_t  q_wdata
);

    logic [1:0] phase_reg, phase_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] dx_reg, dx_next;
    logic       accept;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    // packet phase and byte capture
    always_comb
    begin
        phase_next  = phase_reg;
        status_next = status_reg;
        dx_next     = dx_reg;
        q_push      = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                2'd0:
                begin
                    status_next = s_tdata;
                    phase_next  = 2'd1;
                end
                2'd1:
                begin
                    dx_next    = s_tdata;
                    phase_next = 2'd2;
                end
                default:
                begin
                    // third byte, also taken for the unused phase code
                    phase_next = 2'd0;
                    q_push     = 1'b1;
                end
            endcase
        end
    end

    assign q_wdata.buttons = status_reg[2:0] & BTN_MASK;
    assign q_wdata.delta_x = dx_reg;
    assign q_wdata.delta_y = s_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 2'd0;
            status_reg <= 8'd0;
            dx_reg     <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            dx_reg     <= dx_next;
        end
    end

endmodule

FILE: src/mpct_queue.sv
// short packet queue between front and back end
`include "assert_macros.svh"

module mpct_queue
    import mpct_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  mpct_entry_t  wdata,
    input  logic         pop,
    output mpct_entry_t  rdata,
    output mpct_q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mpct_entry_t      entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

    `MPCT_ASSERT_NEVER(a_push_full, clk, rst_n, push && stat.full, "push into full queue")
    `MPCT_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && stat.empty, "pop from empty queue")
    `MPCT_ASSERT(a_empty_ptrs, clk, rst_n, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "empty queue with unequal pointers")

endmodule

FILE: src/mpct_div.sv
// serial signed divider by an 8-bit unsigned divisor, one quotient bit per cycle
module mpct_div
    import mpct_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [POSITION_BITS-1:0] dividend,
    input  logic [7:0]               divisor,
    output mpct_div_stat_t           stat,
    output logic [POSITION_BITS-1:0] quotient
);

    localparam int P     = POSITION_BITS;
    localparam int CNT_W = $clog2(P + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [P-1:0]     mag_reg, mag_next;
    logic [7:0]       rem_reg, rem_next;
    logic [7:0]       dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic [8:0]       trial;
    logic [8:0]       diff;
    logic             take;

    // restoring step on the magnitude
    assign trial = {rem_reg, mag_reg[P-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign take  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            cnt_next = CNT_W'(P);
            mag_next = dividend[P-1] ? (~dividend + 1'b1) : dividend;
            rem_next = 8'd0;
            dvs_next = divisor;
            neg_next = dividend[P-1];
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = take ? diff[7:0] : trial[7:0];
            mag_next  = {mag_reg[P-2:0], take};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // truncation toward zero: apply the sign to the magnitude quotient
    assign quotient  = neg_reg ? (~mag_reg + 1'b1) : mag_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

FILE: src/mpct_back.sv
// back end: position update, edge checks and scaled cursor output
`include "assert_macros.svh"

module mpct_back
    import mpct_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  mpct_cfg_t    cfg,
    input  mpct_q_stat_t q_stat,
    input  mpct_entry_t  q_rdata,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata
);

    localparam int P = POSITION_BITS;
    localparam int W = POSITION_BITS + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_XNEW = 3'd1;
    localparam logic [2:0] S_XOLD = 3'd2;
    localparam logic [2:0] S_YNEW = 3'd3;
    localparam logic [2:0] S_YOLD = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [P-1:0] pos_x_reg, pos_x_next;
    logic [P-1:0] pos_y_reg, pos_y_next;
    logic [7:0]   dx_reg, dx_next;
    logic [7:0]   dy_reg, dy_next;
    logic [2:0]   btn_reg, btn_next;
    logic [9:0]   col_reg, col_next;
    logic [9:0]   row_reg, row_next;
    logic         out_valid_reg, out_valid_next;
    logic [23:0]  out_data_reg, out_data_next;

    logic           div_start;
    logic [P-1:0]   div_arg;
    mpct_div_stat_t div_stat;
    logic [P-1:0]   quo;

    logic [P-1:0]        nx_first;
    logic [P-1:0]        nx;
    logic [P-1:0]        ny;
    logic signed [W-1:0] q_ext;
    logic signed [W-1:0] row_new;
    logic signed [W-1:0] lim_x;
    logic signed [W-1:0] lim_y;
    logic                x_bad;
    logic                y_bad;

    mpct_div #(
        .POSITION_BITS(P)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_arg),
        .divisor (cfg.sensitivity),
        .stat    (div_stat),
        .quotient(quo)
    );

    // candidate positions, wrapping sums
    assign nx_first = pos_x_reg + {{(P-8){q_rdata.delta_x[7]}}, q_rdata.delta_x};
    assign nx       = pos_x_reg + {{(P-8){dx_reg[7]}}, dx_reg};
    assign ny       = pos_y_reg + {{(P-8){dy_reg[7]}}, dy_reg};

    // edge checks on the scaled coordinate
    assign q_ext   = {{2{quo[P-1]}}, quo};
    assign row_new = $signed({{(W-10){1'b0}}, cfg.bottom_row}) - q_ext;
    assign lim_x   = $signed({{(W-11){1'b0}}, cfg.screen_width}) - W'(EDGE_MARGIN);
    assign lim_y   = $signed({{(W-11){1'b0}}, cfg.screen_height}) - W'(EDGE_MARGIN);
    assign x_bad   = (q_ext < 0) || (q_ext >= lim_x);
    assign y_bad   = (row_new < 0) || (row_new >= lim_y);

    // packet sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        btn_next       = btn_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_arg        = nx;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    dx_next    = q_rdata.delta_x;
                    dy_next    = q_rdata.delta_y;
                    btn_next   = q_rdata.buttons;
                    div_start  = 1'b1;
                    div_arg    = nx_first;
                    state_next = S_XNEW;
                end
            end
            S_XNEW:
            begin
                if (div_stat.done)
                begin
                    div_start = 1'b1;
                    if (!x_bad)
                    begin
                        pos_x_next = nx;
                        col_next   = quo[9:0];
                        div_arg    = ny;
                        state_next = S_YNEW;
                    end
                    else
                    begin
                        div_arg    = pos_x_reg;
                        state_next = S_XOLD;
                    end
                end
            end
            S_XOLD:
            begin
                if (div_stat.done)
                begin
                    col_next   = quo[9:0];
                    div_start  = 1'b1;
                    div_arg    = ny;
                    state_next = S_YNEW;
                end
            end
            S_YNEW:
            begin
                if (div_stat.done)
                begin
                    if (!y_bad)
                    begin
                        pos_y_next = ny;
                        row_next   = row_new[9:0];
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_arg    = pos_y_reg;
                        state_next = S_YOLD;
                    end
                end
            end
            S_YOLD:
            begin
                if (div_stat.done)
                begin
                    row_next   = row_new[9:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, btn_reg, row_reg, col_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        btn_reg      <= btn_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `MPCT_ASSERT(a_div_start_idle, clk, rst_n, div_start |-> !div_stat.busy, "divider restarted while busy")
    `MPCT_ASSERT(a_done_waiting, clk, rst_n, div_stat.done |-> (state_reg != S_IDLE && state_reg != S_EMIT), "quotient arrived with no request waiting")
    `MPCT_ASSERT(a_pos_x_commit, clk, rst_n, !$stable(pos_x_reg) |-> $past(state_reg == S_XNEW && div_stat.done), "x position changed outside its check")

endmodule

FILE: src/mouse_packet_cursor_tracker_unit.sv
// top level of the mouse packet cursor tracker
// Takes raw PS/2 mouse bytes on the slave stream, groups them into status, X delta and
// Y delta packets, and for every completed packet emits one request holding the cursor
// column, row and the three button bits. Each byte is taken while the front queue has
// room. The back end per packet runs two to four serial divisions on one shared
// divider (the second division of an axis only when its move is undone); the result
// waits in an output register while the next packet is already being worked on.
// Configuration is to be written through the cfg channel only while no packet is in
// flight; the block itself does not enforce this. A sensitivity of zero is stored as
// one. No start-up sweep is needed after reset.
module mouse_packet_cursor_tracker_unit
    import mpct_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [9:0] cursor_column, [19:10] cursor_row,
                                     // [22:20] buttons, [23] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    mpct_cfg_t    cfg_reg, cfg_next;
    mpct_q_stat_t q_stat;
    mpct_entry_t  q_wdata;
    mpct_entry_t  q_rdata;
    logic         q_push;
    logic         q_pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SENSITIVITY:
                begin
                    cfg_next.sensitivity = (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
                end
                CFG_WIDTH:
                begin
                    cfg_next.screen_width = cfg_data;
                end
                CFG_HEIGHT:
                begin
                    cfg_next.screen_height = cfg_data;
                end
                CFG_BOTTOM:
                begin
                    cfg_next.bottom_row = cfg_data[9:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensitivity   <= SENS_RESET;
            cfg_reg.screen_width  <= WIDTH_RESET;
            cfg_reg.screen_height <= HEIGHT_RESET;
            cfg_reg.bottom_row    <= BOTTOM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // packet assembly
    mpct_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    // packet queue
    mpct_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .wdata(q_wdata),
        .pop  (q_pop),
        .rdata(q_rdata),
        .stat (q_stat)
    );

    // position tracking and output
    mpct_back #(
        .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_stat  (q_stat),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

FILE: dv/mpct_cursor_checker.sv
`timescale 1ns / 1ps
// checker that tracks the byte, config and report streams and scores every cursor report
module mpct_cursor_checker
    import mpct_pkg::*;
#(
    parameter int POS_W = POSITION_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          bytes_seen,
    output int          reports_seen,
    output int          undo_count,
    output int          wrap_count
);

    typedef struct packed {
        logic [9:0] column;
        logic [9:0] row;
        logic [2:0] buttons;
    } cursor_report_t;

    mpct_cfg_t        regs;
    logic [1:0]       byte_slot;
    logic [7:0]       status_q;
    logic [7:0]       delta_x_q;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    cursor_report_t   expected_reports[$];

    // position to screen units, signed division truncating toward zero
    function automatic int scale_pos(input logic [POS_W-1:0] p);
        return int'($signed(p)) / int'(regs.sensitivity);
    endfunction

    // register write, zero sensitivity kept at one
    task automatic store_reg(input logic [1:0] idx, input logic [10:0] value);
        case (idx)
            CFG_SENSITIVITY: regs.sensitivity = (value[7:0] == 8'd0) ? 8'd1 : value[7:0];
            CFG_WIDTH:       regs.screen_width = value;
            CFG_HEIGHT:      regs.screen_height = value;
            CFG_BOTTOM:      regs.bottom_row = value[9:0];
            default:         ;
        endcase
    endtask

    // packet assembly and cursor update for one mouse byte
    task automatic take_byte(input logic [7:0] value);
        logic [POS_W-1:0] nx;
        logic [POS_W-1:0] ny;
        logic [POS_W-1:0] dx_ext;
        logic [POS_W-1:0] dy_ext;
        int               col;
        int               row;
        cursor_report_t   rep;
        bytes_seen++;
        if (byte_slot == 2'd0) begin
            status_q  = value;
            byte_slot = 2'd1;
        end else if (byte_slot == 2'd1) begin
            delta_x_q = value;
            byte_slot = 2'd2;
        end else begin
            byte_slot = 2'd0;
            dx_ext = {{(POS_W-8){delta_x_q[7]}}, delta_x_q};
            dy_ext = {{(POS_W-8){value[7]}}, value};

            // x axis, undone when the column leaves the screen
            nx = pos_x + dx_ext;
            if (int'($signed(pos_x)) + int'($signed(delta_x_q)) != int'($signed(nx)))
                wrap_count++;
            col = scale_pos(nx);
            if (col < 0 || col >= int'(regs.screen_width) - EDGE_MARGIN)
                undo_count++;
            else
                pos_x = nx;

            // y axis, flipped against the bottom row
            ny = pos_y + dy_ext;
            if (int'($signed(pos_y)) + int'($signed(value)) != int'($signed(ny)))
                wrap_count++;
            row = int'(regs.bottom_row) - scale_pos(ny);
            if (row < 0 || row >= int'(regs.screen_height) - EDGE_MARGIN)
                undo_count++;
            else
                pos_y = ny;

            col = scale_pos(pos_x);
            row = int'(regs.bottom_row) - scale_pos(pos_y);
            rep.column  = col[9:0];
            rep.row     = row[9:0];
            rep.buttons = status_q[2:0] & BTN_MASK;
            expected_reports.push_back(rep);
        end
    endtask

    // compare one report request against the oldest prediction
    task automatic check_report(input logic [23:0] word);
        cursor_report_t got;
        cursor_report_t exp_rep;
        got.column  = word[9:0];
        got.row     = word[19:10];
        got.buttons = word[22:20];
        reports_seen++;
        if (expected_reports.size() == 0) begin
            fail_count++;
            $display("%0t: report with none predicted: column %0d row %0d buttons %b",
                     $time, got.column, got.row, got.buttons);
        end else begin
            exp_rep = expected_reports.pop_front();
            if (got.column !== exp_rep.column) begin
                fail_count++;
                $display("%0t: cursor_column expected %0d got %0d",
                         $time, exp_rep.column, got.column);
            end
            if (got.row !== exp_rep.row) begin
                fail_count++;
                $display("%0t: cursor_row expected %0d got %0d",
                         $time, exp_rep.row, got.row);
            end
            if (got.buttons !== exp_rep.buttons) begin
                fail_count++;
                $display("%0t: buttons expected %b got %b",
                         $time, exp_rep.buttons, got.buttons);
            end
        end
    endtask

    // watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            regs.sensitivity   = SENS_RESET;
            regs.screen_width  = WIDTH_RESET;
            regs.screen_height = HEIGHT_RESET;
            regs.bottom_row    = BOTTOM_RESET;
            byte_slot          = 2'd0;
            status_q           = 8'd0;
            delta_x_q          = 8'd0;
            pos_x              = '0;
            pos_y              = '0;
            expected_reports.delete();
            fail_count         = 0;
            pending            = 0;
            bytes_seen         = 0;
            reports_seen       = 0;
            undo_count         = 0;
            wrap_count         = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                store_reg(cfg_index, cfg_data);
            if (m_tvalid && m_tready)
                check_report(m_tdata);
            if (s_tvalid && s_tready)
                take_byte(s_tdata);
            pending = expected_reports.size();
        end
    end

endmodule

FILE: dv/mouse_packet_cursor_tracker_unit_test.sv
`timescale 1ns / 1ps
// testbench top: byte stimulus, config phases, report back-pressure and the verdict
module mouse_packet_cursor_tracker_unit_test;
    import mpct_pkg::*;

    typedef enum int {DRIFT_ANY, DRIFT_UP, DRIFT_DOWN, DRIFT_FINE} drift_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;    // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;             // [9:0] column, [19:10] row, [22:20] buttons, [23] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [10:0] cfg_data  = 11'd0;

    int fail_count;
    int pending;
    int bytes_seen;
    int reports_seen;
    int undo_count;
    int wrap_count;

    int bytes_sent = 0;
    int burst_left = 0;
    int reg_writes = 0;
    bit hold_req   = 1'b0;

    // status, x delta, y delta: button patterns, delta extremes, truncation and undo cases
    logic [7:0] directed_bytes [0:23] = '{
        8'hFF, 8'h7F, 8'h80,
        8'h00, 8'h80, 8'h7F,
        8'h01, 8'h00, 8'h00,
        8'h02, 8'hFF, 8'h01,
        8'h04, 8'h01, 8'hFF,
        8'hF8, 8'h55, 8'hAA,
        8'h07, 8'h7F, 8'h7F,
        8'h03, 8'h81, 8'h81
    };

    mouse_packet_cursor_tracker_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mpct_cursor_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .bytes_seen   (bytes_seen),
        .reports_seen (reports_seen),
        .undo_count   (undo_count),
        .wrap_count   (wrap_count)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("[mouse_packet_cursor_tracker_unit] ERROR");
        $finish;
    end

    // report side back-pressure, with one long hold on request
    initial
    begin
        int pct;
        int span;
        @(posedge rst_n);
        forever
        begin
            case ($urandom_range(0, 4))
                0, 1:    pct = 100;
                2:       pct = 75;
                3:       pct = 40;
                default: pct = 10;
            endcase
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_req)
                begin
                    m_tready <= 1'b0;
                    repeat (600) @(negedge clk);
                    hold_req = 1'b0;
                end
                else
                begin
                    m_tready <= ($urandom_range(1, 100) <= pct);
                end
            end
        end
    end

    // delta byte for the chosen drift
    function automatic logic [7:0] pick_delta(input drift_t drift);
        int v;
        case (drift)
            DRIFT_UP:   v = $urandom_range(120, 127);
            DRIFT_DOWN: v = -int'($urandom_range(96, 128));
            DRIFT_FINE: v = int'($urandom_range(0, 16)) - 8;
            default:    v = $urandom_range(0, 255);
        endcase
        return v[7:0];
    endfunction

    // one byte request, entered and left at a falling edge, with bursts and gaps
    task automatic push_byte(input logic [7:0] value);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    // config write request; valid is left high for the next write
    task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        reg_writes++;
    endtask

    // stop sending and wait until every report is out and the back end is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    // one phase: realign, drain, reconfigure, then random packets
    task automatic run_phase(input logic [10:0] sens, input logic [10:0] width,
                             input logic [10:0] height, input logic [10:0] bottom,
                             input int packets, input drift_t drift, input bit long_hold);
        while (bytes_sent % 3 != 0) push_byte(8'($urandom));
        settle();
        write_reg(CFG_SENSITIVITY, sens);
        write_reg(CFG_WIDTH, width);
        write_reg(CFG_HEIGHT, height);
        write_reg(CFG_BOTTOM, bottom);
        cfg_valid <= 1'b0;
        if (long_hold)
            hold_req = 1'b1;
        repeat (packets)
        begin
            // stray byte that shifts the packet framing
            if (drift != DRIFT_UP && $urandom_range(0, 99) < 3)
                push_byte(8'($urandom));
            push_byte(8'($urandom));
            push_byte(pick_delta(drift));
            push_byte(pick_delta(drift));
        end
    endtask

    // stimulus
    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed packets at reset settings
        foreach (directed_bytes[i])
            push_byte(directed_bytes[i]);

        // zero sensitivity, narrowest screen
        run_phase(11'd0, 11'd17, 11'd17, 11'd0, 40, DRIFT_FINE, 1'b0);
        // largest divisor, steady push until both positions wrap
        run_phase(11'd255, 11'd1024, 11'd1024, 11'd1000, 280, DRIFT_UP, 1'b0);
        // back down from the top of the range
        run_phase(11'd64, 11'd1024, 11'd1024, 11'd1023, 40, DRIFT_DOWN, 1'b0);
        // small screen with a long report stall
        run_phase(11'd200, 11'd640, 11'd480, 11'd300, 40, DRIFT_ANY, 1'b1);
        // sensitivity byte of zero, no room on either axis
        run_phase(11'd256, 11'd16, 11'd0, 11'd511, 20, DRIFT_ANY, 1'b0);
        // widest settings
        run_phase(11'd128, 11'd2047, 11'd2047, 11'd1023, 30, DRIFT_FINE, 1'b0);

        settle();
        $display("run covered %0d mouse bytes, %0d cursor reports, %0d register writes",
                 bytes_seen, reports_seen, reg_writes);
        $display("axis moves undone: %0d, position wraps: %0d", undo_count, wrap_count);
        if (fail_count == 0 && pending == 0)
            $display("[mouse_packet_cursor_tracker_unit] OK");
        else
            $display("[mouse_packet_cursor_tracker_unit] ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/mpct_pkg.sv
src/mpct_front.sv
src/mpct_queue.sv
src/mpct_div.sv
src/mpct_back.sv
src/mouse_packet_cursor_tracker_unit.sv
dv/mpct_cursor_checker.sv
dv/mouse_packet_cursor_tracker_unit_test.sv
